// ----- design/gsm_pkg.sv -----
// Shared types and constants for the gradient sharpness measure.
// Holds controller states, register indexes and the controller/datapath structs.
// No dependencies.
package gsm_pkg;

    localparam int SUM_BITS      = 41;
    localparam int RESULT_BITS   = 32;
    localparam int CFG_BITS      = 13;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RESET  = 13'd512;
    localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RESET = 13'd512;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        S_RUN,
        S_DRAIN,
        S_LOAD,
        S_DIV
    } state_t;

    typedef struct packed {
        logic pix_fire;
        logic restart;
        logic div_load;
        logic div_run;
        logic res_load;
    } cmd_t;

    typedef struct packed {
        logic frame_last;
        logic sum_ready;
        logic div_done;
        logic out_free;
    } stat_t;

endpackage

// ----- design/gsm_ctrl.sv -----
// Controller state machine for the gradient sharpness measure.
// Sequences pixel intake, pipeline drain, division and result hand-off.
// Depends on gsm_pkg.
module gsm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            cfg_write,
    input  gsm_pkg::stat_t  stat,
    output logic            in_stall,
    output gsm_pkg::cmd_t   cmd
);

    gsm_pkg::state_t state_reg;
    gsm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gsm_pkg::S_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.restart  = cfg_write;
        in_stall     = 1'b1;
        unique case (state_reg)
            gsm_pkg::S_RUN:
            begin
                in_stall     = 1'b0;
                cmd.pix_fire = in_valid;
                if (in_valid && stat.frame_last)
                begin
                    state_next = gsm_pkg::S_DRAIN;
                end
            end
            gsm_pkg::S_DRAIN:
            begin
                // hold until the last gradient has reached the sum
                if (stat.sum_ready)
                begin
                    state_next = gsm_pkg::S_LOAD;
                end
            end
            gsm_pkg::S_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = gsm_pkg::S_DIV;
            end
            gsm_pkg::S_DIV:
            begin
                cmd.div_run = !stat.div_done;
                if (stat.div_done && stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = gsm_pkg::S_RUN;
                end
            end
            default:
            begin
                state_next = gsm_pkg::S_RUN;
            end
        endcase
    end

    a_fire_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pix_fire |-> state_reg == gsm_pkg::S_RUN)
        else $error("pixel transfer outside the run state");

    a_drain_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        stat.sum_ready |=> state_reg == gsm_pkg::S_LOAD)
        else $error("final sum not followed by divider load");

    a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> stat.div_done && stat.out_free)
        else $error("result loaded before division finished");

endmodule

// ----- design/gsm_datapath.sv -----
// Datapath of the gradient sharpness measure: line store, gradient pipeline,
// running sum, restoring divider and output register.
// Depends on gsm_pkg.
module gsm_datapath #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int PIXEL_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  gsm_pkg::cmd_t                        cmd,
    input  logic signed [PIXEL_BITS-1:0]         pixel,
    input  logic [gsm_pkg::CFG_BITS-1:0]         frame_width,
    input  logic [gsm_pkg::CFG_BITS-1:0]         frame_height,
    input  logic                                 out_stall,
    output gsm_pkg::stat_t                       stat,
    output logic                                 out_valid,
    output logic [gsm_pkg::RESULT_BITS-1:0]      sharpness_q16,
    output logic [gsm_pkg::SUM_BITS-1:0]         gradient_sum
);

    localparam int COL_BITS  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_BITS  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WCMP_BITS = (gsm_pkg::CFG_BITS > COL_BITS + 1) ?
                               gsm_pkg::CFG_BITS : COL_BITS + 1;
    localparam int HCMP_BITS = (gsm_pkg::CFG_BITS > ROW_BITS + 1) ?
                               gsm_pkg::CFG_BITS : ROW_BITS + 1;
    localparam int D_BITS    = COL_BITS + ROW_BITS + 2;
    localparam int STEPS     = gsm_pkg::SUM_BITS + FRAC_BITS;
    localparam int CNT_BITS  = $clog2(STEPS + 1);
    localparam int G_BITS    = PIXEL_BITS + 1;
    localparam int SB        = gsm_pkg::SUM_BITS;
    localparam int RB        = gsm_pkg::RESULT_BITS;

    // clamp the sizes: zero counts as one, above the maximum counts as the maximum
    logic [WCMP_BITS-1:0] w_ext;
    logic [HCMP_BITS-1:0] h_ext;
    logic [COL_BITS-1:0]  w_last;
    logic [ROW_BITS-1:0]  h_last;

    assign w_ext = WCMP_BITS'(frame_width);
    assign h_ext = HCMP_BITS'(frame_height);

    always_comb
    begin
        priority if (w_ext == '0)
            w_last = '0;
        else if (w_ext > WCMP_BITS'(MAX_WIDTH))
            w_last = COL_BITS'(MAX_WIDTH - 1);
        else
            w_last = COL_BITS'(w_ext - WCMP_BITS'(1));

        priority if (h_ext == '0)
            h_last = '0;
        else if (h_ext > HCMP_BITS'(MAX_HEIGHT))
            h_last = ROW_BITS'(MAX_HEIGHT - 1);
        else
            h_last = ROW_BITS'(h_ext - HCMP_BITS'(1));
    end

    // divisor 2*w*h, registered after the multiplier
    logic [D_BITS-1:0] d_reg;
    always_ff @(posedge clk)
    begin
        d_reg <= D_BITS'({1'b0, w_last} + (COL_BITS + 1)'(1))
                 * D_BITS'({1'b0, h_last} + (ROW_BITS + 1)'(1))
                 * D_BITS'(2);
    end

    // raster counters
    logic [COL_BITS-1:0] col_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic                col_end;
    logic                row_end;

    assign col_end         = (col_reg == w_last);
    assign row_end         = (row_reg == h_last);
    assign stat.frame_last = col_end && row_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.pix_fire)
        begin
            if (col_end)
            begin
                col_reg <= '0;
                row_reg <= row_end ? '0 : row_reg + ROW_BITS'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_BITS'(1);
            end
        end
    end

    // line store: read the upper neighbour before overwriting it
    logic signed [PIXEL_BITS-1:0] row_mem [MAX_WIDTH];
    logic signed [PIXEL_BITS-1:0] up_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.pix_fire)
        begin
            up_reg           <= row_mem[col_reg];
            row_mem[col_reg] <= pixel;
        end
    end

    // stage 1: current and left pixel
    logic signed [PIXEL_BITS-1:0] cur_reg;
    logic signed [PIXEL_BITS-1:0] left_reg;
    logic signed [PIXEL_BITS-1:0] left1_reg;
    logic                         v1_reg;
    logic                         q1_reg;
    logic                         last1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            v1_reg    <= 1'b0;
            q1_reg    <= 1'b0;
            last1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.pix_fire;
            if (cmd.restart)
            begin
                left_reg <= '0;
            end
            else if (cmd.pix_fire)
            begin
                left_reg <= pixel;
            end
            if (cmd.pix_fire)
            begin
                q1_reg    <= (col_reg != '0) && (row_reg != '0);
                last1_reg <= stat.frame_last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pix_fire)
        begin
            cur_reg   <= pixel;
            left1_reg <= left_reg;
        end
    end

    // stage 2: gradient
    logic signed [PIXEL_BITS:0] dl;
    logic signed [PIXEL_BITS:0] du;
    logic [PIXEL_BITS-1:0]      al;
    logic [PIXEL_BITS-1:0]      au;
    logic [G_BITS-1:0]          g_reg;
    logic                       v2_reg;
    logic                       q2_reg;
    logic                       last2_reg;

    assign dl = (PIXEL_BITS + 1)'(cur_reg) - (PIXEL_BITS + 1)'(left1_reg);
    assign du = (PIXEL_BITS + 1)'(cur_reg) - (PIXEL_BITS + 1)'(up_reg);
    assign al = dl[PIXEL_BITS] ? PIXEL_BITS'(-dl) : PIXEL_BITS'(dl);
    assign au = du[PIXEL_BITS] ? PIXEL_BITS'(-du) : PIXEL_BITS'(du);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg    <= 1'b0;
            q2_reg    <= 1'b0;
            last2_reg <= 1'b0;
        end
        else
        begin
            v2_reg    <= v1_reg;
            q2_reg    <= q1_reg;
            last2_reg <= last1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg <= G_BITS'(al) + G_BITS'(au);
    end

    assign stat.sum_ready = v2_reg && last2_reg;

    // stage 3: running sum, wraps at its width
    logic [SB-1:0] sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (cmd.restart || cmd.div_load)
        begin
            sum_reg <= '0;
        end
        else if (v2_reg && q2_reg)
        begin
            sum_reg <= sum_reg + SB'(g_reg);
        end
    end

    // restoring divider, one quotient bit per cycle, sticky saturation
    logic [SB-1:0]     num_reg;
    logic [SB-1:0]     hold_reg;
    logic [D_BITS-1:0] rem_reg;
    logic [RB-1:0]     quo_reg;
    logic              ovf_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [D_BITS:0]   shifted;
    logic              ge;

    assign shifted       = {rem_reg, num_reg[SB-1]};
    assign ge            = (shifted >= {1'b0, d_reg});
    assign stat.div_done = (cnt_reg == CNT_BITS'(STEPS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_load)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.div_run)
        begin
            cnt_reg <= cnt_reg + CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            num_reg  <= sum_reg;
            hold_reg <= sum_reg;
            rem_reg  <= '0;
            quo_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (cmd.div_run)
        begin
            num_reg <= {num_reg[SB-2:0], 1'b0};
            rem_reg <= ge ? D_BITS'(shifted - {1'b0, d_reg}) : D_BITS'(shifted);
            quo_reg <= {quo_reg[RB-2:0], ge};
            ovf_reg <= ovf_reg | quo_reg[RB-1];
        end
    end

    // output register
    logic          out_valid_reg;
    logic [RB-1:0] res_reg;
    logic [SB-1:0] res_sum_reg;

    assign stat.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_reg     <= ovf_reg ? '1 : quo_reg;
            res_sum_reg <= hold_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sharpness_q16 = res_reg;
    assign gradient_sum  = res_sum_reg;

    a_no_pixels_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_run |-> !v1_reg && !v2_reg)
        else $error("gradient pipeline busy while dividing");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.res_load))
        else $error("result valid without a result load");

    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_load |=> sum_reg == '0)
        else $error("running sum not cleared at frame end");

endmodule

// ----- design/gradient_sharpness_measure.sv -----
// Gradient sharpness measure: per-frame sum of absolute horizontal and
// vertical pixel differences, scaled by 2*width*height.
//
// Input channel: one signed pixel per transfer in raster order (in_valid,
// in_stall, pixel). Output channel: one result per frame (out_valid,
// out_stall, sharpness_q16, gradient_sum). Frame width and height are set
// over the APB port (byte address 0 and byte address 4); any write restarts the frame.
//
// Pixels within a frame are taken one per cycle. After the last pixel of a
// frame the input is stalled while the two gradient stages drain into the
// sum and a restoring divider then produces one quotient bit per cycle.
// The result sits in an output register, so the next frame's pixels are
// taken while it waits; only if a second result is ready before the first
// is taken does the block hold at the end of the divide until out_stall
// drops.
//
// Reset clears the counters, the sum and the output valid, and sets both
// sizes to 512. The line store is not cleared: each entry is written by the
// previous row before it is read.
module gradient_sharpness_measure #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int PIXEL_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [gsm_pkg::APB_ADDR_BITS-1:0]      paddr,
    input  logic [gsm_pkg::APB_DATA_BITS-1:0]      pwdata,
    output logic [gsm_pkg::APB_DATA_BITS-1:0]      prdata,
    output logic                                   pready,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [PIXEL_BITS-1:0]           pixel,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [gsm_pkg::RESULT_BITS-1:0]        sharpness_q16,
    output logic [gsm_pkg::SUM_BITS-1:0]           gradient_sum
);

    logic [gsm_pkg::CFG_BITS-1:0] width_reg;
    logic [gsm_pkg::CFG_BITS-1:0] height_reg;
    logic                         cfg_write;
    gsm_pkg::reg_idx_t            reg_idx;
    gsm_pkg::cmd_t                cmd;
    gsm_pkg::stat_t               stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = gsm_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= gsm_pkg::FRAME_WIDTH_RESET;
            height_reg <= gsm_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                gsm_pkg::REG_FRAME_WIDTH:  width_reg  <= pwdata[gsm_pkg::CFG_BITS-1:0];
                gsm_pkg::REG_FRAME_HEIGHT: height_reg <= pwdata[gsm_pkg::CFG_BITS-1:0];
                default:                   width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            gsm_pkg::REG_FRAME_WIDTH:  prdata = gsm_pkg::APB_DATA_BITS'(width_reg);
            gsm_pkg::REG_FRAME_HEIGHT: prdata = gsm_pkg::APB_DATA_BITS'(height_reg);
            default:                   prdata = '0;
        endcase
    end

    gsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .cfg_write (cfg_write),
        .stat      (stat),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    gsm_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .pixel         (pixel),
        .frame_width   (width_reg),
        .frame_height  (height_reg),
        .out_stall     (out_stall),
        .stat          (stat),
        .out_valid     (out_valid),
        .sharpness_q16 (sharpness_q16),
        .gradient_sum  (gradient_sum)
    );

endmodule

// ----- dv/tb_gradient_sharpness_measure.sv -----
// Self-checking testbench for gradient_sharpness_measure: streams frames of pixels,
// sets frame sizes over APB and checks each per-frame result against its own predictor.
// Depends on gsm_pkg and the gradient_sharpness_measure RTL.
module tb_gradient_sharpness_measure;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM      = 4096;
    localparam int PIX_BITS     = 16;
    localparam int FRAC         = 16;
    localparam int SETTLE_WAIT  = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int RAND_PIXELS  = 950;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int HI_BITS      = gsm_pkg::APB_DATA_BITS - gsm_pkg::CFG_BITS;

    typedef struct packed {
        logic [gsm_pkg::RESULT_BITS-1:0] q16;
        logic [gsm_pkg::SUM_BITS-1:0]    sum;
    } frame_result_t;

    typedef enum int {
        PX_NOISE,
        PX_SMOOTH,
        PX_EXTREME,
        PX_SPARSE
    } px_style_t;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   psel = 1'b0;
    logic                                   penable = 1'b0;
    logic                                   pwrite = 1'b0;
    logic [gsm_pkg::APB_ADDR_BITS-1:0]      paddr = '0;
    logic [gsm_pkg::APB_DATA_BITS-1:0]      pwdata = '0;
    logic [gsm_pkg::APB_DATA_BITS-1:0]      prdata;
    logic                                   pready;
    logic                                   in_valid = 1'b0;
    logic                                   in_stall;
    logic signed [PIX_BITS-1:0]             pixel = '0;
    logic                                   out_valid;
    logic                                   out_stall = 1'b0;
    logic [gsm_pkg::RESULT_BITS-1:0]        sharpness_q16;
    logic [gsm_pkg::SUM_BITS-1:0]           gradient_sum;

    gradient_sharpness_measure dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel         (pixel),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sharpness_q16 (sharpness_q16),
        .gradient_sum  (gradient_sum)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state
    logic [gsm_pkg::CFG_BITS-1:0]   size_reg [2];
    logic signed [PIX_BITS-1:0]     line_buf [MAX_DIM];
    logic signed [PIX_BITS-1:0]     left_px;
    int                             col_cnt;
    int                             row_cnt;
    logic [gsm_pkg::SUM_BITS-1:0]   grad_acc;
    frame_result_t                  frame_results [$];

    // Stimulus and bookkeeping
    logic signed [PIX_BITS-1:0] pix_q [$];
    logic [PIX_BITS-1:0]        last_gen;
    int                         px_offered;
    int                         px_taken;
    int                         px_gap;
    int                         px_pushed;
    bit                         no_idle;
    bit                         hold_req;
    int                         hold_left;
    bit                         rx_stalled;
    int                         rx_run;
    int                         error_cnt;
    int                         cycle_cnt;
    frame_result_t              got_exp;

    initial
    begin
        size_reg[gsm_pkg::REG_FRAME_WIDTH]  = gsm_pkg::FRAME_WIDTH_RESET;
        size_reg[gsm_pkg::REG_FRAME_HEIGHT] = gsm_pkg::FRAME_HEIGHT_RESET;
        foreach (line_buf[i])
            line_buf[i] = '0;
        left_px    = '0;
        col_cnt    = 0;
        row_cnt    = 0;
        grad_acc   = '0;
        last_gen   = '0;
        px_offered = 0;
        px_taken   = 0;
        px_gap     = 0;
        px_pushed  = 0;
        no_idle    = 1'b0;
        hold_req   = 1'b0;
        hold_left  = 0;
        rx_stalled = 1'b0;
        rx_run     = 0;
        error_cnt  = 0;
        cycle_cnt  = 0;
    end

    function automatic void flag_error(string msg);
        error_cnt++;
        if (error_cnt <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function automatic int eff_size(logic [gsm_pkg::CFG_BITS-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return int'(v);
    endfunction

    function automatic int abs_diff(int a, int b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic void restart_frame();
        col_cnt  = 0;
        row_cnt  = 0;
        grad_acc = '0;
        left_px  = '0;
    endfunction

    // Advance the frame by one pixel; queue the frame result on its last pixel.
    function automatic void take_pixel(logic signed [PIX_BITS-1:0] p);
        int            w;
        int            h;
        int            col;
        int            g;
        logic [63:0]   q;
        frame_result_t r;
        w = eff_size(size_reg[gsm_pkg::REG_FRAME_WIDTH]);
        h = eff_size(size_reg[gsm_pkg::REG_FRAME_HEIGHT]);
        col = col_cnt;
        if (col >= w)
            col = w - 1;
        if (row_cnt >= h)
            row_cnt = h - 1;
        if (col >= 1 && row_cnt >= 1)
        begin
            g = abs_diff(int'(p), int'(left_px)) + abs_diff(int'(p), int'(line_buf[col]));
            grad_acc = grad_acc + gsm_pkg::SUM_BITS'(g);
        end
        line_buf[col] = p;
        left_px = p;
        if (col == w - 1)
        begin
            if (row_cnt == h - 1)
            begin
                q = {{(64 - gsm_pkg::SUM_BITS - FRAC){1'b0}}, grad_acc, {FRAC{1'b0}}}
                    / (64'(2) * 64'(w) * 64'(h));
                r.q16 = (q > 64'hFFFF_FFFF) ? '1 : q[gsm_pkg::RESULT_BITS-1:0];
                r.sum = grad_acc;
                frame_results.push_back(r);
                restart_frame();
            end
            else
            begin
                col_cnt = 0;
                row_cnt++;
            end
        end
        else
            col_cnt = col + 1;
    endfunction

    function automatic int idle_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int stall_len(bit stalling);
        int r;
        r = $urandom_range(0, 99);
        if (stalling)
            return (r < 75) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        return (r < 80) ? $urandom_range(1, 12) : $urandom_range(20, 60);
    endfunction

    function automatic logic [PIX_BITS-1:0] gen_pixel(px_style_t style);
        logic [PIX_BITS-1:0] v;
        case (style)
            PX_SMOOTH:  v = last_gen + PIX_BITS'($urandom_range(0, 64)) - PIX_BITS'(32);
            PX_EXTREME:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 16'h8000;
                    1:       v = 16'h7FFF;
                    2:       v = 16'h0000;
                    default: v = 16'hFFFF;
                endcase
            end
            PX_SPARSE:  v = PIX_BITS'($urandom & $urandom);
            default:    v = PIX_BITS'($urandom);
        endcase
        last_gen = v;
        return v;
    endfunction

    // Input side: offer pixels at the falling edge, hold until the transfer.
    always @(negedge clk)
    begin
        if (rst_n && px_offered == px_taken)
        begin
            if (px_gap > 0)
            begin
                px_gap--;
                in_valid <= 1'b0;
            end
            else if (pix_q.size() > 0)
            begin
                in_valid <= 1'b1;
                pixel    <= pix_q[0];
                px_offered++;
                px_gap = idle_len();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            take_pixel(pixel);
            void'(pix_q.pop_front());
            px_taken++;
        end
    end

    // Output side stall: a long hold-off on request, else alternating runs (none while no_idle is set).
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (no_idle)
            out_stall <= 1'b0;
        else
        begin
            if (rx_run == 0)
            begin
                rx_stalled = !rx_stalled;
                rx_run = stall_len(rx_stalled);
            end
            rx_run--;
            out_stall <= rx_stalled;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (frame_results.size() == 0)
                flag_error($sformatf("result with none pending: q16=%h sum=%h",
                                     sharpness_q16, gradient_sum));
            else
            begin
                got_exp = frame_results.pop_front();
                if (sharpness_q16 !== got_exp.q16)
                    flag_error($sformatf("sharpness_q16 exp %h got %h",
                                         got_exp.q16, sharpness_q16));
                if (gradient_sum !== got_exp.sum)
                    flag_error($sformatf("gradient_sum exp %h got %h",
                                         got_exp.sum, gradient_sum));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic apb_access(input logic wr, input gsm_pkg::reg_idx_t idx,
                              input logic [gsm_pkg::APB_DATA_BITS-1:0] wdata,
                              output logic [gsm_pkg::APB_DATA_BITS-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_size(input gsm_pkg::reg_idx_t idx);
        logic [gsm_pkg::APB_DATA_BITS-1:0] rd;
        apb_access(1'b0, idx, '0, rd);
        if (rd !== gsm_pkg::APB_DATA_BITS'(size_reg[idx]))
            flag_error($sformatf("register %s read exp %h got %h",
                                 idx.name(), gsm_pkg::APB_DATA_BITS'(size_reg[idx]), rd));
    endtask

    task automatic set_size(input gsm_pkg::reg_idx_t idx,
                            input logic [gsm_pkg::APB_DATA_BITS-1:0] word);
        logic [gsm_pkg::APB_DATA_BITS-1:0] rd;
        apb_access(1'b1, idx, word, rd);
        size_reg[idx] = word[gsm_pkg::CFG_BITS-1:0];
        restart_frame();
        check_size(idx);
    endtask

    // Wait until every pixel is taken and every result has arrived, then let
    // the block finish any divide still in progress.
    task automatic settle();
        while (pix_q.size() != 0 || px_offered != px_taken || frame_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic run_frames(input bit wr_w, input bit wr_h,
                              input logic [gsm_pkg::APB_DATA_BITS-1:0] w_word,
                              input logic [gsm_pkg::APB_DATA_BITS-1:0] h_word,
                              input int frames, input bit want_tail,
                              input px_style_t style);
        int area;
        int n;
        settle();
        if (wr_w)
            set_size(gsm_pkg::REG_FRAME_WIDTH, w_word);
        if (wr_h)
            set_size(gsm_pkg::REG_FRAME_HEIGHT, h_word);
        area = eff_size(size_reg[gsm_pkg::REG_FRAME_WIDTH])
               * eff_size(size_reg[gsm_pkg::REG_FRAME_HEIGHT]);
        n = frames * area;
        if (want_tail && area > 1)
            n += $urandom_range(1, area - 1);
        repeat (n)
            pix_q.push_back(gen_pixel(style));
        px_pushed += n;
    endtask

    function automatic int pick_dim(bit narrow);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 0;
        if (narrow)
            return $urandom_range(1, 4);
        if (r < 70)
            return $urandom_range(1, 6);
        if (r < 90)
            return $urandom_range(7, 16);
        return $urandom_range(17, 64);
    endfunction

    initial
    begin : stimulus
        int                                base;
        int                                w;
        int                                h;
        int                                sel;
        logic [gsm_pkg::APB_DATA_BITS-1:0] w_word;
        logic [gsm_pkg::APB_DATA_BITS-1:0] h_word;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        check_size(gsm_pkg::REG_FRAME_WIDTH);
        check_size(gsm_pkg::REG_FRAME_HEIGHT);

        // Directed: extreme pixels, zero sizes, one-row and one-column frames
        run_frames(1'b1, 1'b1, 3, 3, 1, 1'b0, PX_EXTREME);
        run_frames(1'b1, 1'b1, 0, 5, 1, 1'b0, PX_NOISE);
        run_frames(1'b1, 1'b1, 4, 0, 1, 1'b0, PX_NOISE);
        run_frames(1'b1, 1'b1, 2, 2, 0, 1'b0, PX_NOISE);
        pix_q.push_back(16'sh7FFF);
        pix_q.push_back(-16'sh8000);
        pix_q.push_back(-16'sh8000);
        pix_q.push_back(16'sh7FFF);

        // Size words with the upper bits set: only the low register bits count
        run_frames(1'b1, 1'b1, 32'hFFFF_E005, 32'hFFFF_E002, 1, 1'b0, PX_NOISE);
        run_frames(1'b1, 1'b1, 1, 32'hFFFF_E007, 1, 1'b1, PX_SMOOTH);
        run_frames(1'b1, 1'b1, 32'hFFFF_E009, 1, 1, 1'b0, PX_SMOOTH);

        // Hold the output off long enough that the block must stall its input
        run_frames(1'b1, 1'b1, 4, 3, 8, 1'b0, PX_NOISE);
        hold_req = 1'b1;

        base = px_pushed;
        while (px_pushed - base < RAND_PIXELS)
        begin
            w = pick_dim(1'b0);
            h = pick_dim(w > 16);
            w_word = gsm_pkg::APB_DATA_BITS'(w);
            h_word = gsm_pkg::APB_DATA_BITS'(h);
            if ($urandom_range(0, 3) == 0)
                w_word[gsm_pkg::APB_DATA_BITS-1:gsm_pkg::CFG_BITS] = HI_BITS'($urandom);
            if ($urandom_range(0, 3) == 0)
                h_word[gsm_pkg::APB_DATA_BITS-1:gsm_pkg::CFG_BITS] = HI_BITS'($urandom);
            sel = $urandom_range(0, 9);
            no_idle = ($urandom_range(0, 6) == 0);
            run_frames(sel != 0 && sel != 2, sel != 0 && sel != 1, w_word, h_word,
                       (w * h > 64) ? 1 : $urandom_range(1, 3),
                       $urandom_range(0, 2) == 0,
                       px_style_t'($urandom_range(0, 3)));
        end
        no_idle = 1'b0;

        settle();
        if (error_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
